FILE: rtl/etmt_pkg.sv
package etmt_pkg;

  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned AVG_W    = 32;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [ALPHA_W-1:0] VOLT_ALPHA_RST   = 16'd6554;
  localparam logic [ALPHA_W-1:0] AMP_ALPHA_RST    = 16'd6554;
  localparam logic [ALPHA_W-1:0] CHARGE_ALPHA_RST = 16'd6554;
  localparam logic [THR_W-1:0]   VOLT_THR_RST     = 15'd5;
  localparam logic [THR_W-1:0]   AMP_THR_RST      = 15'd20;
  localparam logic [THR_W-1:0]   CHARGE_THR_RST   = 15'd100;

  localparam logic [CHAN_W-1:0] CH_HOUSE_VOLTS   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_HOUSE_AMPS    = 2'd1;
  localparam logic [CHAN_W-1:0] CH_HOUSE_CHARGE  = 2'd2;
  localparam logic [CHAN_W-1:0] CH_STARTER_VOLTS = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_VOLT_ALPHA   = 3'd0,
    REG_AMP_ALPHA    = 3'd1,
    REG_CHARGE_ALPHA = 3'd2,
    REG_VOLT_THR     = 3'd3,
    REG_AMP_THR      = 3'd4,
    REG_CHARGE_THR   = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_e;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ALPHA_W-1:0]         alpha;
    logic [THR_W-1:0]           thr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/etmt_queue.sv
module etmt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  etmt_pkg::item_t   item_i,
  input  logic              pop_i,
  output etmt_pkg::item_t   item_o,
  output etmt_pkg::q_status_t stat_o
);
  import etmt_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

FILE: rtl/etmt_front.sv
module etmt_front #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [etmt_pkg::CHAN_W-1:0]       channel_i,
  input  logic signed [etmt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [etmt_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [etmt_pkg::DATA_W-1:0]       cfg_data_i,
  input  etmt_pkg::q_status_t               q_stat_i,
  output logic                              push_o,
  output etmt_pkg::item_t                   item_o
);
  import etmt_pkg::*;

  logic [ALPHA_W-1:0] volt_alpha_q, amp_alpha_q, charge_alpha_q;
  logic [THR_W-1:0]   volt_thr_q, amp_thr_q, charge_thr_q;
  logic               accept, in_range;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat_i.full;
  assign accept      = in_valid_i && !q_stat_i.full;
  assign in_range    = (32'(channel_i) < CHANNELS);
  assign push_o      = accept && in_range;

  // Pick the channel's smoothing factor and threshold.
  always_comb begin
    item_o.channel = channel_i;
    item_o.sample  = sample_i;
    case (channel_i)
      CH_HOUSE_AMPS: begin
        item_o.alpha = amp_alpha_q;
        item_o.thr   = amp_thr_q;
      end
      CH_HOUSE_CHARGE: begin
        item_o.alpha = charge_alpha_q;
        item_o.thr   = charge_thr_q;
      end
      default: begin
        item_o.alpha = volt_alpha_q;
        item_o.thr   = volt_thr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_alpha_q   <= VOLT_ALPHA_RST;
      amp_alpha_q    <= AMP_ALPHA_RST;
      charge_alpha_q <= CHARGE_ALPHA_RST;
      volt_thr_q     <= VOLT_THR_RST;
      amp_thr_q      <= AMP_THR_RST;
      charge_thr_q   <= CHARGE_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VOLT_ALPHA:   volt_alpha_q   <= cfg_data_i;
        REG_AMP_ALPHA:    amp_alpha_q    <= cfg_data_i;
        REG_CHARGE_ALPHA: charge_alpha_q <= cfg_data_i;
        REG_VOLT_THR:     volt_thr_q     <= cfg_data_i[THR_W-1:0];
        REG_AMP_THR:      amp_thr_q      <= cfg_data_i[THR_W-1:0];
        REG_CHARGE_THR:   charge_thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  a_push_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (accept && (32'(item_o.channel) < CHANNELS)))
    else $error("pushed an item for a channel that does not exist");

endmodule

FILE: rtl/etmt_back.sv
module etmt_back #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  etmt_pkg::q_status_t                   q_stat_i,
  input  etmt_pkg::item_t                       item_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [etmt_pkg::CHAN_W-1:0]           channel_out_o,
  output logic signed [etmt_pkg::SAMPLE_W-1:0]  min_value_o,
  output logic signed [etmt_pkg::SAMPLE_W-1:0]  max_value_o,
  output logic [1:0]                            trend_o,
  output logic                                  first_sample_o
);
  import etmt_pkg::*;

  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0]        seen_q;
  logic signed [SAMPLE_W-1:0] min_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] max_q [CHANNELS];
  logic [AVG_W-1:0]           avg_q [CHANNELS];
  logic [AVG_W-1:0]           ref_q [CHANNELS];

  logic                       out_valid_q;
  logic [CHAN_W-1:0]          out_ch_q;
  logic signed [SAMPLE_W-1:0] out_min_q, out_max_q;
  trend_e                     out_trend_q;
  logic                       out_first_q;

  logic [CH_IDX_W-1:0]        idx;
  logic                       seen_cur;
  logic signed [SAMPLE_W-1:0] x, min_cur, max_cur, min_new, max_new;
  logic [AVG_W-1:0]           avg_cur, ref_cur, avg_new, ref_new, xq;
  logic signed [32:0]         xq_s, avg_s, d_s, diff_s, th_s, neg_th_s;
  logic signed [16:0]         alpha_s;
  logic signed [49:0]         prod_s;
  logic signed [33:0]         step_s, sum_s;
  trend_e                     trend_new;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  assign idx      = CH_IDX_W'(item_i.channel);
  assign seen_cur = seen_q[idx];
  assign min_cur  = min_q[idx];
  assign max_cur  = max_q[idx];
  assign avg_cur  = avg_q[idx];
  assign ref_cur  = ref_q[idx];
  assign x        = item_i.sample;
  assign xq       = {x, 16'h0000};

  // Average step: floor(alpha * (x - avg) / 2^16), taken as the upper product bits.
  assign xq_s     = {x[SAMPLE_W-1], x, 16'h0000};
  assign avg_s    = {avg_cur[AVG_W-1], avg_cur};
  assign d_s      = xq_s - avg_s;
  assign alpha_s  = {1'b0, item_i.alpha};
  assign prod_s   = alpha_s * d_s;
  assign step_s   = prod_s[49:16];
  assign sum_s    = {avg_cur[AVG_W-1], avg_cur[AVG_W-1], avg_cur} + step_s;

  // Trend compare against the reference, threshold in Q16.16.
  assign diff_s   = {sum_s[AVG_W-1], sum_s[AVG_W-1:0]} - {ref_cur[AVG_W-1], ref_cur};
  assign th_s     = {2'b00, item_i.thr, 16'h0000};
  assign neg_th_s = -th_s;

  always_comb begin
    if (!seen_cur) begin
      min_new   = x;
      max_new   = x;
      avg_new   = xq;
      ref_new   = xq;
      trend_new = TREND_NONE;
    end else begin
      min_new   = (x < min_cur) ? x : min_cur;
      max_new   = (x > max_cur) ? x : max_cur;
      avg_new   = sum_s[AVG_W-1:0];
      ref_new   = ref_cur;
      trend_new = TREND_NONE;
      if (diff_s >= th_s) begin
        trend_new = TREND_UP;
      end else if (diff_s <= neg_th_s) begin
        trend_new = TREND_DOWN;
      end else begin
        ref_new = sum_s[AVG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        seen_q[idx] <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      min_q[idx]  <= min_new;
      max_q[idx]  <= max_new;
      avg_q[idx]  <= avg_new;
      ref_q[idx]  <= ref_new;
      out_ch_q    <= item_i.channel;
      out_min_q   <= min_new;
      out_max_q   <= max_new;
      out_trend_q <= trend_new;
      out_first_q <= !seen_cur;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_out_o  = out_ch_q;
  assign min_value_o    = out_min_q;
  assign max_value_o    = out_max_q;
  assign trend_o        = out_trend_q;
  assign first_sample_o = out_first_q;

  a_first_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !seen_cur) |=> (out_valid_q && out_first_q))
    else $error("seeding beat not flagged as first sample");

  a_first_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_first_q) |-> (out_trend_q == TREND_NONE))
    else $error("first sample reported a trend");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_min_q <= out_max_q))
    else $error("reported minimum above maximum");

endmodule

FILE: rtl/ema_trend_minmax_tracker.sv
// Channel  | Direction | Handshake                | Beat contents
// ---------+-----------+--------------------------+---------------------------------------
// in       | input     | in_valid_i / in_stall_o  | channel_i, sample_i
// out      | output    | out_valid_o / out_stall_i| channel_out_o, min/max_value_o,
//          |           |                          | trend_o, first_sample_o
// cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One sample beat per cycle sustained while the output is not stalled. A beat
// passes the front stage in the cycle it is taken, is written into the two-entry
// queue, and the back stage's per-channel update (one 17x33 multiply, add,
// compare) lands it in the output register. Reset clears the per-channel seen
// bits and the queue, and loads the register reset values; per-channel
// statistics need no clearing. A stall on the output holds the result register;
// the queue then fills and in_stall_o rises once it holds two beats.
// cfg_ready_o is always high.
module ema_trend_minmax_tracker #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [etmt_pkg::CHAN_W-1:0]           channel_i,
  input  logic signed [etmt_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [etmt_pkg::CHAN_W-1:0]           channel_out_o,
  output logic signed [etmt_pkg::SAMPLE_W-1:0]  min_value_o,
  output logic signed [etmt_pkg::SAMPLE_W-1:0]  max_value_o,
  output logic [1:0]                            trend_o,
  output logic                                  first_sample_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [etmt_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [etmt_pkg::DATA_W-1:0]           cfg_data_i
);
  import etmt_pkg::*;

  q_status_t q_stat;
  item_t     push_item, pop_item;
  logic      push, pop;

  // Front: hold config, pick alpha and threshold, drop absent channels.
  etmt_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Queue: decouple the front from output back-pressure.
  etmt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  // Back: advance the channel's min, max, average and trend reference.
  etmt_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_out_o  (channel_out_o),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .trend_o        (trend_o),
    .first_sample_o (first_sample_o)
  );

endmodule

FILE: tb/etmt_stat_checker.sv
`timescale 1ns / 1ps
module etmt_stat_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [etmt_pkg::CHAN_W-1:0]          channel_i,
  input  logic signed [etmt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [etmt_pkg::CHAN_W-1:0]          channel_out_i,
  input  logic signed [etmt_pkg::SAMPLE_W-1:0] min_value_i,
  input  logic signed [etmt_pkg::SAMPLE_W-1:0] max_value_i,
  input  logic [1:0]                           trend_i,
  input  logic                                 first_sample_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [etmt_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [etmt_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                 wrap_up_i,
  output int unsigned                          mismatch_count_o,
  output int unsigned                          waiting_o
);
  import etmt_pkg::*;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    trend_e                     trend;
    logic                       first;
  } stat_beat_t;

  stat_beat_t expected_stats[$];

  logic                       seen_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] min_q  [NUM_CH];
  logic signed [SAMPLE_W-1:0] max_q  [NUM_CH];
  logic signed [AVG_W-1:0]    avg_q  [NUM_CH];
  logic signed [AVG_W-1:0]    ref_q  [NUM_CH];

  logic [ALPHA_W-1:0] volt_alpha, amp_alpha, charge_alpha;
  logic [THR_W-1:0]   volt_thr, amp_thr, charge_thr;
  bit                 leftovers_done;

  initial begin
    mismatch_count_o = 0;
    waiting_o        = 0;
    leftovers_done   = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= PRINT_CAP) $display("[%0t] checker: %s", $time, what);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  // Advance the per-channel statistics by one sample and return the result beat.
  function automatic stat_beat_t predict_stats(input logic [CHAN_W-1:0] ch,
                                               input logic signed [SAMPLE_W-1:0] x);
    stat_beat_t         beat;
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   thr;
    longint             step, diff, limit;
    case (ch)
      CH_HOUSE_AMPS: begin
        alpha = amp_alpha;
        thr   = amp_thr;
      end
      CH_HOUSE_CHARGE: begin
        alpha = charge_alpha;
        thr   = charge_thr;
      end
      default: begin
        alpha = volt_alpha;
        thr   = volt_thr;
      end
    endcase
    beat.channel = ch;
    beat.trend   = TREND_NONE;
    beat.first   = 1'b0;
    if (!seen_q[ch]) begin
      seen_q[ch] = 1'b1;
      min_q[ch]  = x;
      max_q[ch]  = x;
      avg_q[ch]  = {x, 16'h0000};
      ref_q[ch]  = {x, 16'h0000};
      beat.first = 1'b1;
    end else begin
      if (x < min_q[ch]) min_q[ch] = x;
      if (x > max_q[ch]) max_q[ch] = x;
      // arithmetic shift of the signed product floors toward minus infinity
      step = (longint'(alpha) * ((longint'(x) <<< 16) - longint'(avg_q[ch]))) >>> 16;
      avg_q[ch] = avg_q[ch] + step[AVG_W-1:0];
      diff  = longint'(avg_q[ch]) - longint'(ref_q[ch]);
      limit = longint'(thr) <<< 16;
      if (diff >= limit) begin
        beat.trend = TREND_UP;
      end else if (diff <= -limit) begin
        beat.trend = TREND_DOWN;
      end else begin
        ref_q[ch] = avg_q[ch];
      end
    end
    beat.lo = min_q[ch];
    beat.hi = max_q[ch];
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stat_beat_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) seen_q[c] = 1'b0;
      volt_alpha   = VOLT_ALPHA_RST;
      amp_alpha    = AMP_ALPHA_RST;
      charge_alpha = CHARGE_ALPHA_RST;
      volt_thr     = VOLT_THR_RST;
      amp_thr      = AMP_THR_RST;
      charge_thr   = CHARGE_THR_RST;
      expected_stats.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_VOLT_ALPHA:   volt_alpha   = cfg_data_i;
          REG_AMP_ALPHA:    amp_alpha    = cfg_data_i;
          REG_CHARGE_ALPHA: charge_alpha = cfg_data_i;
          REG_VOLT_THR:     volt_thr     = cfg_data_i[THR_W-1:0];
          REG_AMP_THR:      amp_thr      = cfg_data_i[THR_W-1:0];
          REG_CHARGE_THR:   charge_thr   = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting: a beat taken this edge cannot leave this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("result beat on channel %0d with none pending",
                                    channel_out_i));
        end else begin
          want = expected_stats.pop_front();
          check_field("channel_out", channel_out_i, want.channel);
          check_field("min_value", min_value_i, want.lo);
          check_field("max_value", max_value_i, want.hi);
          check_field("trend", trend_i, want.trend);
          check_field("first_sample", first_sample_i, want.first);
        end
      end
      if (in_valid_i && !in_stall_i) expected_stats.push_back(predict_stats(channel_i, sample_i));
      if (wrap_up_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (expected_stats.size() != 0)
          report_mismatch($sformatf("%0d result beats never arrived", expected_stats.size()));
      end
    end
    waiting_o = expected_stats.size();
  end

endmodule

FILE: tb/tb_ema_trend_minmax_tracker.sv
`timescale 1ns / 1ps
module tb_ema_trend_minmax_tracker;
  import etmt_pkg::*;

  localparam int unsigned RANDOM_SAMPLES = 600;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned CALM_PHASE     = 4;
  // indexes past the last register; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [CHAN_W-1:0]          channel      = '0;
  logic signed [SAMPLE_W-1:0] sample       = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [CHAN_W-1:0]          channel_out;
  logic signed [SAMPLE_W-1:0] min_value;
  logic signed [SAMPLE_W-1:0] max_value;
  logic [1:0]                 trend;
  logic                       first_sample;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index    = '0;
  logic [DATA_W-1:0]          cfg_data     = '0;
  logic                       wrap_up      = 1'b0;

  int unsigned mismatch_count;
  int unsigned waiting;
  int unsigned samples_sent = 0;
  int unsigned reg_writes   = 0;
  int unsigned settings     = 1;
  bit          calm         = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  ema_trend_minmax_tracker i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .channel_i      (channel),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .channel_out_o  (channel_out),
    .min_value_o    (min_value),
    .max_value_o    (max_value),
    .trend_o        (trend),
    .first_sample_o (first_sample),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  etmt_stat_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .channel_i        (channel),
    .sample_i         (sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .channel_out_i    (channel_out),
    .min_value_i      (min_value),
    .max_value_i      (max_value),
    .trend_i          (trend),
    .first_sample_i   (first_sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .wrap_up_i        (wrap_up),
    .mismatch_count_o (mismatch_count),
    .waiting_o        (waiting)
  );

  // Take a break with a chance of about 30 in 100, except during the calm stretch.
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  // Receiver side: stall the result channel at random, decided at the falling edge.
  always @(negedge clk) out_stall <= take_break();

  // Offer one sample beat and hold it steady until the block takes it.
  // Entered and left at a falling edge, so the next beat can follow directly.
  task automatic push_sample(input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] value);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  // Drop valid and wait for every predicted result, then keep idling before the
  // caller goes on, so nothing in the pipeline is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leave cfg_valid high so back-to-back writes need one assignment per edge;
  // the caller drops it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    reg_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_alpha();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return VOLT_ALPHA_RST;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Thresholds are 15 bits wide; keep the spare top bit random to prove it is dropped.
  function automatic logic [DATA_W-1:0] pick_threshold();
    logic [DATA_W-1:0] raw;
    raw = DATA_W'($urandom);
    case ($urandom_range(4))
      0:       return {raw[DATA_W-1], 15'h0000};
      1:       return {raw[DATA_W-1], 15'h7FFF};
      2:       return DATA_W'($urandom_range(300));
      default: return raw;
    endcase
  endfunction

  // Program one setting while the block is idle. The first three phases pin
  // reset values and both extremes; later phases rewrite a random subset.
  task automatic program_setting(input int unsigned phase);
    settle();
    case (phase)
      0: begin
        write_reg(REG_VOLT_ALPHA, VOLT_ALPHA_RST);
        write_reg(REG_AMP_ALPHA, AMP_ALPHA_RST);
        write_reg(REG_CHARGE_ALPHA, CHARGE_ALPHA_RST);
        write_reg(REG_VOLT_THR, DATA_W'(VOLT_THR_RST));
        write_reg(REG_AMP_THR, DATA_W'(AMP_THR_RST));
        write_reg(REG_CHARGE_THR, DATA_W'(CHARGE_THR_RST));
      end
      1: begin
        for (int r = 0; r <= int'(REG_CHARGE_THR); r++)
          write_reg(reg_e'(r), (r <= int'(REG_CHARGE_ALPHA)) ? '1 : 16'h7FFF);
      end
      2: begin
        for (int r = 0; r <= int'(REG_CHARGE_THR); r++) write_reg(reg_e'(r), '0);
      end
      default: begin
        for (int r = 0; r <= int'(REG_CHARGE_THR); r++) begin
          if ($urandom_range(9) < 6)
            write_reg(reg_e'(r),
                      (r <= int'(REG_CHARGE_ALPHA)) ? pick_alpha() : pick_threshold());
        end
        if ($urandom_range(2) == 0)
          write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, DATA_W'($urandom));
      end
    endcase
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // One burst of samples. Mostly ramps and holds on one channel, so the average
  // drifts across the reference and trends appear; the rest is full-range noise.
  task automatic sample_burst();
    logic [CHAN_W-1:0] ch;
    int                len, level, slope, mag, v;
    ch    = CHAN_W'($urandom_range(3));
    len   = $urandom_range(4, 12);
    level = int'($urandom_range(65535)) - 32768;
    case ($urandom_range(9))
      0, 1: begin
        repeat (len) begin
          v = $urandom;
          push_sample(CHAN_W'($urandom_range(3)), v[SAMPLE_W-1:0]);
        end
      end
      2: begin
        repeat (len) push_sample(ch, level[SAMPLE_W-1:0]);
      end
      default: begin
        mag   = $urandom_range(1) ? 40 : 2000;
        slope = int'($urandom_range(2 * mag)) - mag;
        for (int k = 0; k < len; k++) begin
          v = level + slope * k;
          if (v > 32767) v = 32767;
          else if (v < -32768) v = -32768;
          push_sample(ch, v[SAMPLE_W-1:0]);
        end
      end
    endcase
  endtask

  // Hard stop in case the handshakes hang; far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("timeout: %0d samples sent, %0d results still pending", samples_sent, waiting);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned directed;
    int unsigned phase_end;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Seed every channel with an extreme: top, bottom, zero and all ones.
    push_sample(CH_HOUSE_VOLTS, 16'sh7FFF);
    push_sample(CH_HOUSE_AMPS, 16'sh8000);
    push_sample(CH_HOUSE_CHARGE, 16'sh0000);
    push_sample(CH_STARTER_VOLTS, 16'shFFFF);
    // Full-scale swings: new minimum with a falling trend, new maximum rising.
    push_sample(CH_HOUSE_VOLTS, 16'sh8000);
    push_sample(CH_HOUSE_VOLTS, 16'sh8000);
    push_sample(CH_HOUSE_AMPS, 16'sh7FFF);
    // Charge: hold steady (neutral), then step up so that it reads rising.
    push_sample(CH_HOUSE_CHARGE, 16'sh0000);
    repeat (3) push_sample(CH_HOUSE_CHARGE, 16'sd5000);
    // Starter: tiny moves stay inside the threshold.
    push_sample(CH_STARTER_VOLTS, 16'shFFFF);
    push_sample(CH_STARTER_VOLTS, -16'sd2);

    // Zero voltage alpha and zero threshold, full current alpha with the
    // widest threshold, and writes to the unused indexes.
    settle();
    write_reg(REG_VOLT_ALPHA, '0);
    write_reg(REG_AMP_ALPHA, '1);
    write_reg(REG_CHARGE_ALPHA, 16'd1);
    write_reg(REG_VOLT_THR, '0);
    write_reg(REG_AMP_THR, '1);
    write_reg(REG_CHARGE_THR, '0);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    cfg_valid <= 1'b0;
    settings++;
    push_sample(CH_HOUSE_VOLTS, 16'sd100);
    push_sample(CH_STARTER_VOLTS, 16'shFFFF);
    push_sample(CH_HOUSE_AMPS, 16'sh8000);
    push_sample(CH_HOUSE_CHARGE, 16'sh7FFF);
    push_sample(CH_HOUSE_CHARGE, 16'sh8000);
    directed = samples_sent;

    // Random part, one setting per phase; each phase boundary holds the
    // sender until every expected result is back.
    for (int unsigned p = 0; p < PHASES; p++) begin
      program_setting(p);
      calm      = (p == CALM_PHASE);
      phase_end = samples_sent + RANDOM_SAMPLES / PHASES;
      while (samples_sent < phase_end) sample_burst();
    end
    calm = 1'b0;

    settle();
    wrap_up <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d samples (%0d directed) on all four channels,", samples_sent,
             directed);
    $display("%0d register writes across %0d settings, random stalls on both sides.",
             reg_writes, settings);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/etmt_pkg.sv
rtl/etmt_queue.sv
rtl/etmt_front.sv
rtl/etmt_back.sv
rtl/ema_trend_minmax_tracker.sv
tb/etmt_stat_checker.sv
tb/tb_ema_trend_minmax_tracker.sv
